[hdl/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and codes of the potential field evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int SOURCES_DEF    = 64;
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 8;

   localparam int IDX_BITS   = 6;
   localparam int KIND_BITS  = 2;
   localparam int STR_BITS   = 16;
   localparam int CAP_BITS   = 16;
   localparam int BIAS_BITS  = 8;
   localparam int OUT_BITS   = 25;
   localparam int CSR_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [STR_BITS-1:0]  STRENGTH_RST = 16'd200;
   localparam logic [CAP_BITS-1:0]  CAP_RST      = 16'd2000;
   localparam logic [BIAS_BITS-1:0] BIAS_RST     = 8'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_STRENGTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAP      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIAS     = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_EMPTY    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_OBSTACLE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_GOAL     = 2'd2;

   typedef struct packed {
      logic start;   // load query point, preset accumulator to the bias
      logic step;    // compute the term of the current source
      logic finish;  // saturate and latch the result
   } ctrl_type;

   typedef struct packed {
      logic step_done;
   } stat_type;

endpackage

[hdl/pfe_if.sv]
// ----------------------------------------------------------------------------
// pfe_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface pfe_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/potential_field_evaluator.sv]
// Evaluation: each source in turn passes a bit-serial root and divider.
// A load beat gives no result.
// Throughput: one item at a time; the result is held until taken.
// Reset (synchronous): table empty, registers to 200 / 2000 / 3.
// ----------------------------------------------------------------------------
// potential_field_evaluator
// Top level: channels, register file, controller and datapath.
// ----------------------------------------------------------------------------
module potential_field_evaluator #(
   parameter int SOURCES    = pfe_pkg::SOURCES_DEF,
   parameter int COORD_BITS = pfe_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pfe_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [pfe_pkg::IDX_BITS-1:0]        req_entry_index,
   input  logic [COORD_BITS-1:0]               req_entry_x,
   input  logic [COORD_BITS-1:0]               req_entry_y,
   input  logic [pfe_pkg::KIND_BITS-1:0]       req_entry_kind,
   input  logic [COORD_BITS-1:0]               req_point_x,
   input  logic [COORD_BITS-1:0]               req_point_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pfe_pkg::OUT_BITS-1:0] rsp_potential,
   input  logic                                csr_we,
   input  logic [pfe_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pfe_pkg::CSR_BITS-1:0]        csr_wdata
);
   logic [pfe_pkg::STR_BITS-1:0]  strength_ff;
   logic [pfe_pkg::CAP_BITS-1:0]  cap_ff;
   logic [pfe_pkg::BIAS_BITS-1:0] bias_ff;
   pfe_pkg::ctrl_type ctrl;
   pfe_pkg::stat_type stat;
   logic last_src, load_en;
   logic [pfe_pkg::OUT_BITS-1:0] pot;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= pfe_pkg::STRENGTH_RST;
         cap_ff      <= pfe_pkg::CAP_RST;
         bias_ff     <= pfe_pkg::BIAS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pfe_pkg::CSR_STRENGTH: strength_ff <= csr_wdata;
            pfe_pkg::CSR_CAP:      cap_ff      <= csr_wdata;
            pfe_pkg::CSR_BIAS:     bias_ff     <= csr_wdata[pfe_pkg::BIAS_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign load_en = req_valid && req_ready && (req_command == pfe_pkg::CMD_LOAD);
   assign rsp_potential = pot;

   pfe_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_cmd(req_command), .req_ready,
      .rsp_valid, .rsp_ready, .ctrl, .stat, .last_src
   );

   pfe_dp #(.SOURCES(SOURCES), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .load_en, .load_idx(req_entry_index),
      .load_x(req_entry_x), .load_y(req_entry_y), .load_kind(req_entry_kind),
      .pt_x(req_point_x), .pt_y(req_point_y),
      .strength(strength_ff), .cap(cap_ff), .bias(bias_ff),
      .ctrl, .stat, .last_src, .potential(pot)
   );
endmodule

[hdl/pfe_ctrl.sv]
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: accepts a beat, walks the source table for an evaluation,
// holds the result until taken.
// ----------------------------------------------------------------------------
module pfe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_cmd,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pfe_pkg::ctrl_type  ctrl,
   input  pfe_pkg::stat_type  stat,
   input  logic               last_src
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      acc_eval;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign acc_eval  = req_valid && req_ready && (req_cmd == pfe_pkg::CMD_EVAL);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_eval) begin
               ctrl.start = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
            if (stat.step_done && last_src) state_in = ST_FIN;
         end
         ST_FIN: begin
            ctrl.finish = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

[hdl/pfe_dp.sv]
// ----------------------------------------------------------------------------
// pfe_dp
// Datapath: source table memory with valid bits, serial square root,
// serial divider and the signed accumulator.
// ----------------------------------------------------------------------------
module pfe_dp #(
   parameter int SOURCES    = pfe_pkg::SOURCES_DEF,
   parameter int COORD_BITS = pfe_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pfe_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_en,
   input  logic [pfe_pkg::IDX_BITS-1:0]      load_idx,
   input  logic [COORD_BITS-1:0]             load_x,
   input  logic [COORD_BITS-1:0]             load_y,
   input  logic [pfe_pkg::KIND_BITS-1:0]     load_kind,
   input  logic [COORD_BITS-1:0]             pt_x,
   input  logic [COORD_BITS-1:0]             pt_y,
   input  logic [pfe_pkg::STR_BITS-1:0]      strength,
   input  logic [pfe_pkg::CAP_BITS-1:0]      cap,
   input  logic [pfe_pkg::BIAS_BITS-1:0]     bias,
   input  pfe_pkg::ctrl_type                 ctrl,
   output pfe_pkg::stat_type                 stat,
   output logic                              last_src,
   output logic [pfe_pkg::OUT_BITS-1:0]      potential
);
   localparam int SIDX_BITS = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int SCNT_BITS = $clog2(SOURCES + 1);
   localparam int ENT_BITS  = 2 * COORD_BITS + pfe_pkg::KIND_BITS;
   localparam int D2_BITS   = 2 * COORD_BITS + 1;
   localparam int RT_STEPS  = COORD_BITS + 1 + FRAC_BITS;
   localparam int RT_BITS   = RT_STEPS;
   localparam int REM_BITS  = RT_BITS + 2;
   localparam int NUM_BITS  = pfe_pkg::STR_BITS + 2 * FRAC_BITS;
   localparam int QCAP_BITS = pfe_pkg::CAP_BITS + FRAC_BITS;
   localparam int DREM_BITS = RT_BITS + 1;
   localparam int ACC_BITS  = QCAP_BITS + SIDX_BITS + 3;
   localparam int STEP_BITS = $clog2(RT_STEPS + NUM_BITS + 4);
   localparam logic signed [ACC_BITS-1:0] OUT_MAX =
      ACC_BITS'((64'sd1 <<< (pfe_pkg::OUT_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-1:0] OUT_MIN =
      ACC_BITS'(-(64'sd1 <<< (pfe_pkg::OUT_BITS - 1)));

   typedef enum logic [4:0] {
      PH_READ = 5'b00001,
      PH_SQR  = 5'b00010,
      PH_ROOT = 5'b00100,
      PH_DIV  = 5'b01000,
      PH_ACC  = 5'b10000
   } phase_type;

   logic [ENT_BITS-1:0]  mem [SOURCES];
   logic [SOURCES-1:0]   vld_ff;
   logic [ENT_BITS-1:0]  rd_ff;
   logic                 rd_vld_ff;
   logic [SCNT_BITS-1:0] src_ff;
   phase_type            ph_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [pfe_pkg::KIND_BITS-1:0] kind_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic [D2_BITS-1:0]   d2_ff;
   logic [REM_BITS-1:0]  rem_ff;
   logic [RT_BITS-1:0]   root_ff;
   logic [NUM_BITS-1:0]  num_ff;
   logic [DREM_BITS-1:0] drem_ff;
   logic [NUM_BITS-1:0]  quo_ff;
   logic signed [ACC_BITS-1:0] acc_ff;
   logic [pfe_pkg::OUT_BITS-1:0] pot_ff;
   logic                 done_ff;

   logic [COORD_BITS-1:0] ex, ey;
   logic [1:0]            pair;
   logic [REM_BITS-1:0]   rsh, trial;
   logic [DREM_BITS-1:0]  dsh;
   logic [QCAP_BITS-1:0]  capq;
   logic [NUM_BITS-1:0]   term;
   logic [$clog2(D2_BITS)+1:0] pos;

   always_ff @(posedge clock) begin
      if (load_en && (SOURCES > 1 ? 32'(load_idx) < SOURCES : load_idx == '0))
         mem[SIDX_BITS'(load_idx)] <= {load_x, load_y, load_kind};
      if (ph_ff == PH_READ) rd_ff <= mem[src_ff[SIDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (load_en && 32'(load_idx) < SOURCES)
         vld_ff[SIDX_BITS'(load_idx)] <= 1'b1;
   end

   assign ex   = rd_ff[ENT_BITS-1 -: COORD_BITS];
   assign ey   = rd_ff[pfe_pkg::KIND_BITS +: COORD_BITS];
   assign pos  = ($clog2(D2_BITS)+2)'(2 * (RT_STEPS - 1 - 32'(cnt_ff) - FRAC_BITS));
   assign pair = (32'(cnt_ff) < RT_STEPS - FRAC_BITS) ? 2'(d2_ff >> pos) : 2'b00;
   assign rsh  = {rem_ff[REM_BITS-3:0], pair};
   assign trial = REM_BITS'({root_ff, 2'b01});
   assign dsh  = {drem_ff[DREM_BITS-2:0], num_ff[NUM_BITS-1]};
   assign capq = {cap, FRAC_BITS'(0)};
   assign term = (quo_ff > NUM_BITS'(capq)) ? NUM_BITS'(capq) : quo_ff;

   assign last_src  = (src_ff == SCNT_BITS'(SOURCES - 1));
   assign stat.step_done = done_ff;
   assign potential = pot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_READ;
         done_ff <= 1'b0;
         src_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            px_ff  <= pt_x;
            py_ff  <= pt_y;
            acc_ff <= ACC_BITS'({bias, FRAC_BITS'(0)});
            src_ff <= '0;
            ph_ff  <= PH_READ;
         end else if (ctrl.step && !done_ff) begin
            unique case (ph_ff)
               PH_READ: begin
                  rd_vld_ff <= vld_ff[src_ff[SIDX_BITS-1:0]];
                  ph_ff     <= PH_SQR;
               end
               PH_SQR: begin
                  kind_ff <= rd_vld_ff ? rd_ff[pfe_pkg::KIND_BITS-1:0] : pfe_pkg::KIND_EMPTY;
                  dx_ff   <= (px_ff > ex) ? px_ff - ex : ex - px_ff;
                  dy_ff   <= (py_ff > ey) ? py_ff - ey : ey - py_ff;
                  cnt_ff  <= '1;
                  ph_ff   <= PH_ROOT;
               end
               PH_ROOT: begin
                  if (cnt_ff == '1) begin
                     d2_ff  <= D2_BITS'(dx_ff) * D2_BITS'(dx_ff) +
                               D2_BITS'(dy_ff) * D2_BITS'(dy_ff);
                     rem_ff <= '0;
                     root_ff <= '0;
                     cnt_ff <= '0;
                  end else begin
                     if (rsh >= trial) begin
                        rem_ff  <= rsh - trial;
                        root_ff <= {root_ff[RT_BITS-2:0], 1'b1};
                     end else begin
                        rem_ff  <= rsh;
                        root_ff <= {root_ff[RT_BITS-2:0], 1'b0};
                     end
                     if (32'(cnt_ff) == RT_STEPS - 1) begin
                        cnt_ff  <= '0;
                        num_ff  <= {strength, (2*FRAC_BITS)'(0)};
                        drem_ff <= '0;
                        quo_ff  <= '0;
                        ph_ff   <= PH_DIV;
                     end else cnt_ff <= cnt_ff + 1'b1;
                  end
               end
               PH_DIV: begin
                  num_ff <= {num_ff[NUM_BITS-2:0], 1'b0};
                  if (dsh >= DREM_BITS'(root_ff)) begin
                     drem_ff <= dsh - DREM_BITS'(root_ff);
                     quo_ff  <= {quo_ff[NUM_BITS-2:0], 1'b1};
                  end else begin
                     drem_ff <= dsh;
                     quo_ff  <= {quo_ff[NUM_BITS-2:0], 1'b0};
                  end
                  if (32'(cnt_ff) == NUM_BITS - 1) ph_ff <= PH_ACC;
                  else cnt_ff <= cnt_ff + 1'b1;
               end
               PH_ACC: begin
                  if (root_ff != '0) begin
                     if (kind_ff == pfe_pkg::KIND_OBSTACLE)
                        acc_ff <= acc_ff + ACC_BITS'(term);
                     else if (kind_ff == pfe_pkg::KIND_GOAL)
                        acc_ff <= acc_ff - ACC_BITS'(term);
                  end
                  done_ff <= last_src;
                  ph_ff   <= PH_READ;
                  if (!last_src) src_ff <= src_ff + 1'b1;
               end
               default: ph_ff <= PH_READ;
            endcase
         end
         if (ctrl.finish) begin
            if (acc_ff > OUT_MAX)      pot_ff <= pfe_pkg::OUT_BITS'(OUT_MAX);
            else if (acc_ff < OUT_MIN) pot_ff <= pfe_pkg::OUT_BITS'(OUT_MIN);
            else                       pot_ff <= pfe_pkg::OUT_BITS'(acc_ff);
         end
      end
   end
endmodule

[hdl/pfe_checker.sv]
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [24:0] rsp_potential
);
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_potential))
      else $error("result dropped or changed while stalled");
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("not ready after result taken");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result after reset");
endmodule

bind potential_field_evaluator pfe_checker u_pfe_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_potential
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load and evaluate beats into the potential field evaluator, keeps
// its own copy of the source table and registers, computes the inverse
// distance potential for each evaluate beat and checks every result beat
// against it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic                          command;
      logic [pfe_pkg::IDX_BITS-1:0]  entry_index;
      logic [11:0]                   entry_x;
      logic [11:0]                   entry_y;
      logic [pfe_pkg::KIND_BITS-1:0] entry_kind;
      logic [11:0]                   point_x;
      logic [11:0]                   point_y;
   } req_beat_type;

   typedef logic signed [pfe_pkg::OUT_BITS-1:0] potential_type;

   localparam int STALL_LIMIT = 20000;
   localparam int BEAT_BITS   = $bits(req_beat_type);
   localparam logic [pfe_pkg::CSR_IDX_BITS-1:0] CSR_UNUSED    = 2'd3;
   localparam logic [pfe_pkg::KIND_BITS-1:0]    KIND_RESERVED = 2'd3;

   logic clock;
   logic reset;
   logic                             csr_we;
   logic [pfe_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [pfe_pkg::CSR_BITS-1:0]     csr_wdata;

   pfe_if #(.payload_type(req_beat_type))  req_ch ();
   pfe_if #(.payload_type(potential_type)) rsp_ch ();

   potential_field_evaluator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_command     (req_ch.data.command),
      .req_entry_index (req_ch.data.entry_index),
      .req_entry_x     (req_ch.data.entry_x),
      .req_entry_y     (req_ch.data.entry_y),
      .req_entry_kind  (req_ch.data.entry_kind),
      .req_point_x     (req_ch.data.point_x),
      .req_point_y     (req_ch.data.point_y),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_potential   (rsp_ch.data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // predictor state
   logic [11:0]                   src_x    [pfe_pkg::SOURCES_DEF];
   logic [11:0]                   src_y    [pfe_pkg::SOURCES_DEF];
   logic [pfe_pkg::KIND_BITS-1:0] src_kind [pfe_pkg::SOURCES_DEF];
   logic [pfe_pkg::STR_BITS-1:0]  strength_reg;
   logic [pfe_pkg::CAP_BITS-1:0]  cap_reg;
   logic [pfe_pkg::BIAS_BITS-1:0] bias_reg;

   potential_type expected_potentials[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  idle_enable = 1;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // floor(sqrt(d2) * 256)
   function automatic longint unsigned distance_fixed(longint unsigned d2);
      longint unsigned v;
      longint unsigned res;
      longint unsigned b;
      v = d2 << 16;
      res = 0;
      b = 64'd1 << 42;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint source_term(logic [11:0] px, logic [11:0] py, int i);
      longint unsigned dx;
      longint unsigned dy;
      longint unsigned root_len;
      longint unsigned q;
      longint unsigned cap;
      dx = (px > src_x[i]) ? px - src_x[i] : src_x[i] - px;
      dy = (py > src_y[i]) ? py - src_y[i] : src_y[i] - py;
      root_len = distance_fixed(dx * dx + dy * dy);
      if (root_len == 0) return 0;
      q = (longint'(strength_reg) << 16) / root_len;
      cap = longint'(cap_reg) << 8;
      return (q > cap) ? cap : q;
   endfunction

   function automatic potential_type field_potential(logic [11:0] px, logic [11:0] py);
      longint sum;
      sum = longint'(bias_reg) << 8;
      for (int i = 0; i < pfe_pkg::SOURCES_DEF; i++) begin
         if (src_kind[i] == pfe_pkg::KIND_OBSTACLE) sum += source_term(px, py, i);
         else if (src_kind[i] == pfe_pkg::KIND_GOAL) sum -= source_term(px, py, i);
      end
      if (sum > 64'sd16777215) sum = 64'sd16777215;
      if (sum < -64'sd16777216) sum = -64'sd16777216;
      return potential_type'(sum);
   endfunction

   function automatic void apply_beat(req_beat_type b);
      if (b.command == pfe_pkg::CMD_LOAD) begin
         src_x[b.entry_index]    = b.entry_x;
         src_y[b.entry_index]    = b.entry_y;
         src_kind[b.entry_index] = b.entry_kind;
      end else begin
         expected_potentials.push_back(field_potential(b.point_x, b.point_y));
      end
   endfunction

   function automatic int draw_gap();
      return idle_enable ? $urandom_range(0, 18) : 0;
   endfunction

   task automatic send_beat(req_beat_type b);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= b;
      do @(posedge clock); while (!req_ch.ready);
      apply_beat(b);
   endtask

   function automatic req_beat_type random_beat(logic cmd);
      req_beat_type b;
      b = req_beat_type'(BEAT_BITS'({$urandom, $urandom}));
      b.command = cmd;
      return b;
   endfunction

   task automatic load_source(int idx, int x, int y, logic [pfe_pkg::KIND_BITS-1:0] kind);
      req_beat_type b;
      b = random_beat(pfe_pkg::CMD_LOAD);
      b.entry_index = pfe_pkg::IDX_BITS'(idx);
      b.entry_x = 12'(x);
      b.entry_y = 12'(y);
      b.entry_kind = kind;
      send_beat(b);
   endtask

   task automatic eval_point(int x, int y);
      req_beat_type b;
      b = random_beat(pfe_pkg::CMD_EVAL);
      b.point_x = 12'(x);
      b.point_y = 12'(y);
      send_beat(b);
   endtask

   // hold valid low, wait for all results, let any load finish
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_potentials.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [pfe_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [pfe_pkg::CSR_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == pfe_pkg::CSR_STRENGTH) strength_reg = value;
      else if (idx == pfe_pkg::CSR_CAP) cap_reg = value;
      else if (idx == pfe_pkg::CSR_BIAS) bias_reg = value[pfe_pkg::BIAS_BITS-1:0];
   endtask

   task automatic test_directed();
      eval_point(0, 0);
      load_source(0, 0, 0, pfe_pkg::KIND_OBSTACLE);
      load_source(63, 4095, 4095, pfe_pkg::KIND_GOAL);
      load_source(5, 100, 200, KIND_RESERVED);
      eval_point(0, 0);
      eval_point(4095, 4095);
      eval_point(100, 200);
      eval_point(4095, 0);
      eval_point(1, 0);
      drain();
      write_reg(pfe_pkg::CSR_STRENGTH, 16'd0);
      eval_point(7, 9);
      drain();
      write_reg(pfe_pkg::CSR_STRENGTH, 16'hFFFF);
      write_reg(pfe_pkg::CSR_CAP, 16'hFFFF);
      write_reg(pfe_pkg::CSR_BIAS, 16'h00FF);
      write_reg(CSR_UNUSED, 16'h0000);
      for (int i = 0; i < pfe_pkg::SOURCES_DEF; i++)
         load_source(i, 0, 0, pfe_pkg::KIND_OBSTACLE);
      eval_point(1, 0);
      for (int i = 0; i < pfe_pkg::SOURCES_DEF; i++)
         load_source(i, 0, 1, pfe_pkg::KIND_GOAL);
      eval_point(0, 0);
      eval_point(1, 0);
      drain();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 15) eval_point($urandom_range(0, 4095),
                                                    $urandom_range(0, 4095));
         else send_beat(random_beat(pfe_pkg::CMD_LOAD));
      end
   endtask

   // per spot: drop six sources near a random spot, then evaluate a point near it
   task automatic test_clusters(int count);
      int cx;
      int cy;
      for (int n = 0; n < count; n++) begin
         cx = $urandom_range(0, 4095);
         cy = $urandom_range(0, 4095);
         repeat (6) load_source($urandom_range(0, 63),
                                (cx + $urandom_range(0, 40)) & 12'hFFF,
                                (cy + $urandom_range(0, 40)) & 12'hFFF,
                                pfe_pkg::KIND_BITS'($urandom_range(1, 2)));
         eval_point((cx + $urandom_range(0, 40)) & 12'hFFF,
                    (cy + $urandom_range(0, 40)) & 12'hFFF);
      end
   endtask

   task automatic test_settings();
      write_reg(pfe_pkg::CSR_STRENGTH, pfe_pkg::STRENGTH_RST);
      write_reg(pfe_pkg::CSR_CAP, pfe_pkg::CAP_RST);
      write_reg(pfe_pkg::CSR_BIAS, 16'(pfe_pkg::BIAS_RST));
      test_random(350);
      drain();
      write_reg(pfe_pkg::CSR_CAP, 16'd0);
      write_reg(pfe_pkg::CSR_BIAS, 16'd0);
      write_reg(CSR_UNUSED, 16'($urandom));
      idle_enable = 0;
      test_random(300);
      drain();
      idle_enable = 1;
      write_reg(pfe_pkg::CSR_STRENGTH, 16'($urandom));
      write_reg(pfe_pkg::CSR_CAP, 16'($urandom));
      write_reg(pfe_pkg::CSR_BIAS, 16'($urandom));
      test_clusters(40);
      drain();
      write_reg(pfe_pkg::CSR_STRENGTH, 16'hFFFF);
      write_reg(pfe_pkg::CSR_CAP, 16'hFFFF);
      write_reg(pfe_pkg::CSR_BIAS, 16'h00FF);
      test_random(350);
      drain();
      write_reg(pfe_pkg::CSR_STRENGTH, 16'd1);
      write_reg(pfe_pkg::CSR_CAP, 16'd1);
      test_random(330);
      drain();
   endtask

   initial begin
      for (int i = 0; i < pfe_pkg::SOURCES_DEF; i++) begin
         src_x[i] = 0;
         src_y[i] = 0;
         src_kind[i] = pfe_pkg::KIND_EMPTY;
      end
      strength_reg = pfe_pkg::STRENGTH_RST;
      cap_reg      = pfe_pkg::CAP_RST;
      bias_reg     = pfe_pkg::BIAS_RST;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_settings();
      repeat (100) @(negedge clock);
      if (errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   // result side ready
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_potentials.size() == 0) begin
            $error("potential: expected none actual %0d", rsp_ch.data);
            errors++;
         end else begin
            potential_type want;
            want = expected_potentials.pop_front();
            if (rsp_ch.data !== want) begin
               $error("potential: expected %0d actual %0d", want, rsp_ch.data);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

endmodule
